// ===== hdl/eacc_pkg.sv =====
// eacc_pkg: shared types and constants of the end-around-carry checksum core.
// Holds the command record that the front end queues for the back end.
// No dependencies.
`timescale 1ns / 1ps

package eacc_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int FOLD_W      = 16;
    localparam int PEND_BYTES  = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic MODE_EAC32  = 1'b0;
    localparam logic MODE_FOLD8  = 1'b1;

    typedef enum logic [1:0] {
        OP_WORD,    // add a packed word, may end the message
        OP_TAIL,    // 1 to 3 tail bytes, each added then rotated; ends the message
        OP_FADD,    // 8-bit mode: add byte to 16-bit sum
        OP_FEND     // 8-bit mode: fold and end the message
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               last;
        logic [1:0]         cnt;    // tail: number of steps minus one
        logic [WORD_W-1:0]  data;
    } t_cmd;

endpackage

// ===== hdl/eacc_if.sv =====
// eacc_if: valid/ready channel interfaces of the checksum core.
// Input bytes, output checksums and the mode write channel.
// Depends on nothing.
`timescale 1ns / 1ps

interface eacc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eacc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

interface eacc_cfg_if;
    logic valid;
    logic ready;
    logic checksum_mode;

    modport source (output valid, output checksum_mode, input ready);
    modport sink   (input valid, input checksum_mode, output ready);
endinterface

// ===== hdl/end_around_carry_checksum_core.sv =====
// end_around_carry_checksum_core: top level of the byte-stream checksum core.
// Depends on eacc_pkg, eacc_if, eacc_front, eacc_queue and eacc_back.
`timescale 1ns / 1ps

// Takes one message byte per cycle and returns one checksum per message, on
// the byte marked last. checksum_mode 0 gives the 32-bit end-around-carry
// sum of little-endian words, inverted; mode 1 gives the inverted 8-bit
// folded sum in the low byte. The front end accepts a byte every cycle while
// the command queue (QUEUE_DEPTH entries) has room. The back end retires one
// command per cycle, holding a finishing one while the output stalls, except
// that a 32-bit-mode message whose last byte does not complete a word, with
// k bytes (k = 1..3) after its last full word, takes one end-around add and
// rotate per byte. Sustained rate is one byte per cycle while results are
// taken. Change the mode only while no message is in flight.

module end_around_carry_checksum_core #(
    parameter int QUEUE_DEPTH = eacc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eacc_in_if.sink     i_data,
    eacc_cfg_if.sink    i_cfg,
    eacc_out_if.source  o_result
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    eacc_pkg::t_cmd push_cmd;
    eacc_pkg::t_cmd head_cmd;

    eacc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    eacc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    eacc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

endmodule

// ===== hdl/eacc_queue.sv =====
// eacc_queue: small command queue between front end and back end.
// Depends on eacc_pkg (t_cmd).
`timescale 1ns / 1ps

module eacc_queue #(
    parameter int DEPTH = eacc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  eacc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output eacc_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    eacc_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== hdl/eacc_front.sv =====
// eacc_front: accepts bytes, holds the mode register and the partial word,
// and turns bytes into back-end commands. Depends on eacc_pkg and eacc_if.
`timescale 1ns / 1ps

module eacc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    eacc_in_if.sink        i_data,
    eacc_cfg_if.sink       i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output eacc_pkg::t_cmd o_cmd
);

    logic                                    r_mode;
    logic [eacc_pkg::PEND_BYTES*eacc_pkg::BYTE_W-1:0] r_pend;
    logic [1:0]                              r_cnt;

    logic [eacc_pkg::PEND_BYTES*eacc_pkg::BYTE_W-1:0] n_pend;
    logic [1:0]                              n_cnt;
    logic [eacc_pkg::WORD_W-1:0]             merged;
    logic                                    accept;

    assign i_data.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_data.valid && !i_q_full;

    // partial word with the new byte dropped in at the current fill position
    always_comb begin
        merged = {{eacc_pkg::BYTE_W{1'b0}}, r_pend};
        for (int k = 0; k < 4; k++) begin
            if (r_cnt == 2'(k)) begin
                merged[k*eacc_pkg::BYTE_W +: eacc_pkg::BYTE_W] = i_data.data_byte;
            end
        end
    end

    always_comb begin
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        o_push       = 1'b0;
        o_cmd.op     = eacc_pkg::OP_FADD;
        o_cmd.last   = i_data.last_byte;
        o_cmd.cnt    = r_cnt;
        o_cmd.data   = {{(eacc_pkg::WORD_W-eacc_pkg::BYTE_W){1'b0}}, i_data.data_byte};
        if (r_mode == eacc_pkg::MODE_FOLD8) begin
            o_push   = accept;
            o_cmd.op = i_data.last_byte ? eacc_pkg::OP_FEND : eacc_pkg::OP_FADD;
            if (i_data.last_byte) begin
                n_pend = '0;
                n_cnt  = '0;
            end
        end else if (r_cnt == 2'd3) begin
            o_push     = accept;
            o_cmd.op   = eacc_pkg::OP_WORD;
            o_cmd.data = merged;
            n_pend     = '0;
            n_cnt      = '0;
        end else if (!i_data.last_byte) begin
            n_pend = merged[eacc_pkg::PEND_BYTES*eacc_pkg::BYTE_W-1:0];
            n_cnt  = r_cnt + 2'd1;
        end else begin
            o_push     = accept;
            o_cmd.op   = eacc_pkg::OP_TAIL;
            o_cmd.data = merged;
            n_pend     = '0;
            n_cnt      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= eacc_pkg::MODE_EAC32;
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.checksum_mode;
            end
            if (accept) begin
                r_pend <= n_pend;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

// ===== hdl/eacc_back.sv =====
// eacc_back: runs queued commands on the running sum and registers results.
// Tail bytes take one end-around add and rotate per cycle unless the output
// stalls. Depends on eacc_pkg and eacc_if.
`timescale 1ns / 1ps

module eacc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  eacc_pkg::t_cmd i_q_cmd,
    output logic           o_pop,
    eacc_out_if.source     o_result
);

    localparam int W  = eacc_pkg::WORD_W;
    localparam int BW = eacc_pkg::BYTE_W;

    logic [W-1:0]                           r_sum;
    logic                                   r_tail_busy;
    logic [1:0]                             r_tail_left;
    logic [eacc_pkg::PEND_BYTES*BW-1:0]     r_tail_data;
    logic                                   r_out_valid;
    logic [W-1:0]                           r_out_checksum;

    logic [BW-1:0]                 step_byte;
    logic [W-1:0]                  operand;
    logic [W:0]                    raw;
    logic [W-1:0]                  eac;
    logic [W-1:0]                  rot;
    logic [eacc_pkg::FOLD_W-1:0]   fold16;
    logic [BW-1:0]                 fold8;
    logic [W-1:0]                  n_sum;
    logic [W-1:0]                  result;
    logic                          finish;
    logic                          out_free;
    logic                          advance;

    always_comb begin
        step_byte = r_tail_busy ? r_tail_data[BW-1:0] : i_q_cmd.data[BW-1:0];
        operand   = (!r_tail_busy && i_q_cmd.op == eacc_pkg::OP_WORD)
                    ? i_q_cmd.data : {{(W-BW){1'b0}}, step_byte};
        raw       = {1'b0, r_sum} + {1'b0, operand};
        eac       = raw[W-1:0] + {{(W-1){1'b0}}, raw[W]};
        rot       = {eac[BW-1:0], eac[W-1:BW]};
        fold16    = r_sum[eacc_pkg::FOLD_W-1:0]
                    + {{(eacc_pkg::FOLD_W-BW){1'b0}}, i_q_cmd.data[BW-1:0]};
        fold8     = r_sum[BW-1:0] + r_sum[2*BW-1:BW] + i_q_cmd.data[BW-1:0];

        n_sum  = r_sum;
        finish = 1'b0;
        if (r_tail_busy) begin
            n_sum  = rot;
            finish = (r_tail_left == 2'd1);
        end else begin
            case (i_q_cmd.op)
                eacc_pkg::OP_WORD: begin
                    n_sum  = eac;
                    finish = i_q_cmd.last;
                end
                eacc_pkg::OP_TAIL: begin
                    n_sum  = rot;
                    finish = (i_q_cmd.cnt == 2'd0);
                end
                eacc_pkg::OP_FADD: begin
                    n_sum = {{(W-eacc_pkg::FOLD_W){1'b0}}, fold16};
                end
                eacc_pkg::OP_FEND: begin
                    finish = 1'b1;
                end
                default: begin
                    n_sum = r_sum;
                end
            endcase
        end

        if (!r_tail_busy && i_q_cmd.op == eacc_pkg::OP_FEND) begin
            result = {{(W-BW){1'b0}}, ~fold8};
        end else begin
            result = ~n_sum;
        end

        out_free = !r_out_valid || o_result.ready;
        advance  = (r_tail_busy || i_q_valid) && (!finish || out_free);
        o_pop    = !r_tail_busy && advance;
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.checksum = r_out_checksum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_tail_busy <= 1'b0;
            r_tail_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_sum <= finish ? '0 : n_sum;
            end
            if (advance && r_tail_busy) begin
                r_tail_left <= r_tail_left - 2'd1;
                r_tail_busy <= !finish;
            end else if (o_pop && i_q_cmd.op == eacc_pkg::OP_TAIL && !finish) begin
                r_tail_left <= i_q_cmd.cnt;
                r_tail_busy <= 1'b1;
            end
            if (advance && finish) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && finish) begin
            r_out_checksum <= result;
        end
        if (advance && r_tail_busy) begin
            r_tail_data <= r_tail_data >> BW;
        end else if (o_pop) begin
            r_tail_data <= i_q_cmd.data[W-1:BW];
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_busy |-> (r_tail_left != 2'd0))
        else $error("tail busy with no steps left");
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && finish) |=> (r_out_valid && r_sum == '0))
        else $error("finished message did not post result or clear sum");
    a_tail_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_tail_busy) |-> $past(o_pop))
        else $error("tail sequence started without a popped command");
`endif

endmodule

// ===== verif/tb_end_around_carry_checksum_core.sv =====
// tb_end_around_carry_checksum_core: self-checking bench for the checksum core, with
// directed and random byte messages in both modes, random idling and a long output stall.
// Depends on eacc_pkg, eacc_if and end_around_carry_checksum_core.
`timescale 1ns / 1ps

module tb_end_around_carry_checksum_core;

    localparam realtime CLK_PERIOD = 12.0;
    localparam int DRAIN_CYCLES    = 4 * (eacc_pkg::QUEUE_DEPTH + 2);
    localparam int STALL_CYCLES    = 400;
    localparam int PHASE_BYTES     = 250;
    localparam int LIMIT_CYCLES    = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    logic i_clk;
    logic i_rst_n;

    eacc_in_if  in_bus();
    eacc_cfg_if cfg_bus();
    eacc_out_if out_bus();

    end_around_carry_checksum_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (in_bus),
        .i_cfg    (cfg_bus),
        .o_result (out_bus)
    );

    // predictor state
    logic        mode_q;
    logic [31:0] acc_sum;
    logic [23:0] held_bytes;
    logic [1:0]  held_cnt;

    t_byte_req   bytes_to_send[$];
    logic [31:0] checksums_due[$];
    int unsigned bytes_queued;
    int unsigned bytes_accepted;
    int unsigned mismatches;

    logic calm;
    logic stall_req;
    logic stall_seen;
    int   stall_left;

    function automatic logic [31:0] eac_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[31:0] + {31'd0, s[32]};
    endfunction

    function automatic logic [31:0] eac_tail(input logic [31:0] s, input logic [7:0] b);
        logic [31:0] r;
        r = eac_add(s, {24'd0, b});
        return {r[7:0], r[31:8]};
    endfunction

    // Folds one byte into the message state; returns 1 with the checksum on the last byte.
    function automatic bit absorb_byte(input logic [7:0] b, input logic lst,
                                       output logic [31:0] csum);
        logic [9:0] fold;
        csum = '0;
        if (mode_q == eacc_pkg::MODE_FOLD8) begin
            if (!lst) begin
                acc_sum = {16'd0, acc_sum[15:0] + {8'd0, b}};
                return 1'b0;
            end
            fold = {2'd0, acc_sum[7:0]} + {2'd0, acc_sum[15:8]} + {2'd0, b};
            csum = {24'd0, ~fold[7:0]};
        end else begin
            if (held_cnt == 2'd3) begin
                acc_sum    = eac_add(acc_sum, {b, held_bytes});
                held_bytes = '0;
                held_cnt   = '0;
            end else if (!lst) begin
                held_bytes[8*held_cnt +: 8] = b;
                held_cnt = held_cnt + 2'd1;
            end else begin
                for (int k = 0; k < held_cnt; k++)
                    acc_sum = eac_tail(acc_sum, held_bytes[8*k +: 8]);
                acc_sum = eac_tail(acc_sum, b);
            end
            if (!lst)
                return 1'b0;
            csum = ~acc_sum;
        end
        acc_sum    = '0;
        held_bytes = '0;
        held_cnt   = '0;
        return 1'b1;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin : drive
        logic [31:0] sum;
        t_byte_req   req;
        if (!i_rst_n) begin
            in_bus.valid     <= 1'b0;
            in_bus.data_byte <= '0;
            in_bus.last_byte <= 1'b0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (in_bus.valid) begin
                if (absorb_byte(in_bus.data_byte, in_bus.last_byte, sum))
                    checksums_due.push_back(sum);
                bytes_accepted++;
            end
            if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                req = bytes_to_send.pop_front();
                in_bus.valid     <= 1'b1;
                in_bus.data_byte <= req.data;
                in_bus.last_byte <= req.last;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
            stall_seen <= 1'b0;
        end else if (stall_req != stall_seen) begin
            stall_left <= STALL_CYCLES;
            stall_seen <= stall_req;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        logic [31:0] want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (checksums_due.size() == 0) begin
                    $display("%0t: expected no checksum, actual %08h", $time, out_bus.checksum);
                    mismatches++;
                end else begin
                    want = checksums_due.pop_front();
                    if (out_bus.checksum !== want) begin
                        $display("%0t: checksum expected %08h, actual %08h",
                                 $time, want, out_bus.checksum);
                        mismatches++;
                    end
                end
            end
            out_bus.ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 33);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        bytes_to_send.push_back('{data: b, last: lst});
        bytes_queued++;
    endtask

    task automatic send_message(input int len);
        int r;
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(15);
            b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || checksums_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.checksum_mode <= m;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        mode_q = m;
    endtask

    initial begin : stimulus
        int   sent;
        int   r;
        logic m;
        i_rst_n               = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = '0;
        in_bus.last_byte      = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.checksum_mode = eacc_pkg::MODE_EAC32;
        out_bus.ready         = 1'b0;
        calm                  = 1'b0;
        stall_req             = 1'b0;
        mode_q                = eacc_pkg::MODE_EAC32;
        acc_sum               = '0;
        held_bytes            = '0;
        held_cnt              = '0;
        bytes_queued          = 0;
        bytes_accepted        = 0;
        mismatches            = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: 32-bit mode tails, full final word, word plus three tail bytes
        write_mode(eacc_pkg::MODE_EAC32);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b1);
        // mode switch in the middle of a message, both directions
        send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
        wait_idle();
        write_mode(eacc_pkg::MODE_FOLD8);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
        wait_idle();
        write_mode(eacc_pkg::MODE_EAC32);
        send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b1);
        wait_idle();

        // random phases
        for (int p = 0; p < 8; p++) begin
            m = (p == 0) ? eacc_pkg::MODE_FOLD8 :
                (p == 1) ? eacc_pkg::MODE_EAC32 : logic'($urandom_range(1));
            write_mode(m);
            if (p == 3)
                calm <= 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                r = $urandom_range(99);
                if (r < 50)
                    r = $urandom_range(1, 8);
                else if (r < 85)
                    r = $urandom_range(9, 24);
                else
                    r = $urandom_range(25, 64);
                send_message(r);
                sent += r;
            end
            if (p == 5)
                stall_req <= ~stall_req;
            wait_idle();
            calm <= 1'b0;
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
